// ===== rtl/core/stg_pkg.sv =====
// Package for the spiral trajectory generator: widths, fixed-point constants,
// register indexes, the CORDIC arctangent table and the saturation helper.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package stg_pkg;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = 56;

  // CORDIC datapath width (Q2.30 vectors, Q24 degree angles) and table depth.
  localparam int CW       = 34;
  localparam int ATAN_N   = 24;
  localparam int ATAN_IW  = 5;

  // Configuration register indexes.
  localparam logic [2:0] REG_CENTER_X  = 3'd0;
  localparam logic [2:0] REG_CENTER_Y  = 3'd1;
  localparam logic [2:0] REG_MIN_SPEED = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED = 3'd3;
  localparam logic [2:0] REG_EXP_RATE  = 3'd4;
  localparam logic [2:0] REG_CLOCKWISE = 3'd5;
  localparam logic [2:0] REG_INV_SCALE = 3'd6;

  // Angle constants in Q10.14 degrees (signed, one bit of headroom).
  localparam logic signed [24:0] DEG90_Q14  = 25'sd1474560;
  localparam logic signed [24:0] DEG180_Q14 = 25'sd2949120;
  localparam logic signed [24:0] DEG270_Q14 = 25'sd4423680;
  localparam logic signed [24:0] DEG360_Q14 = 25'sd5898240;

  // Full turn as an unsigned magnitude for the remainder sweep.
  localparam logic [26:0] DEG360_MAG = 27'd5898240;

  // CORDIC start vector length (inverse gain), Q2.30.
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Restart radius, about 0.001 in Q16.16.
  localparam logic [31:0] RADIUS_START = 32'd66;

  // ceil(2^24 / 20): exact quotient by 20 for any 20-bit dividend.
  localparam logic [MUL_B_W-1:0] RECIP20 = 21'd838861;

  // Status and results of the CORDIC unit.
  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] sin_val;
    logic signed [CW-1:0] cos_val;
  } trig_t;

  // atan(2^-i) in Q24 degrees.
  function automatic logic [31:0] atan_deg(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd754974720;
      5'd1:    v = 32'd445687602;
      5'd2:    v = 32'd235489088;
      5'd3:    v = 32'd119537938;
      5'd4:    v = 32'd60000934;
      5'd5:    v = 32'd30029717;
      5'd6:    v = 32'd15018523;
      5'd7:    v = 32'd7509720;
      5'd8:    v = 32'd3754917;
      5'd9:    v = 32'd1877466;
      5'd10:   v = 32'd938734;
      5'd11:   v = 32'd469367;
      5'd12:   v = 32'd234684;
      5'd13:   v = 32'd117342;
      5'd14:   v = 32'd58671;
      5'd15:   v = 32'd29335;
      5'd16:   v = 32'd14668;
      5'd17:   v = 32'd7334;
      5'd18:   v = 32'd3667;
      5'd19:   v = 32'd1833;
      5'd20:   v = 32'd917;
      5'd21:   v = 32'd458;
      5'd22:   v = 32'd229;
      5'd23:   v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp a signed value to the 24-bit signed range.
  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stg_mul.sv =====
// Shared signed multiplier with a registered product for the spiral generator.
// Depends on stg_pkg for the operand and product widths.
`default_nettype none

module stg_mul (
  input  wire logic                                 clk,
  input  wire logic                                 go,
  input  wire logic signed [stg_pkg::MUL_A_W-1:0]   a,
  input  wire logic signed [stg_pkg::MUL_B_W-1:0]   b,
  output      logic signed [stg_pkg::MUL_P_W-1:0]   p
);

  // The product is captured only when a new operation is issued and
  // holds otherwise, so the sequencer can read it in a later state.
  always_ff @(posedge clk) begin
    if (go) begin
      p <= stg_pkg::MUL_P_W'(a * b);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stg_cordic.sv =====
// Iterative CORDIC in degrees: one micro-rotation per cycle gives sin and cos
// in Q2.30 of a Q10.14 angle. Depends on stg_pkg for widths and the atan table.
`default_nettype none

module stg_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [23:0]  angle,
  output      stg_pkg::trig_t      stat
);

  localparam int CW = stg_pkg::CW;
  localparam logic [stg_pkg::ATAN_IW-1:0] LAST = stg_pkg::ATAN_IW'(CORDIC_STEPS - 1);

  logic signed [CW-1:0]          x;
  logic signed [CW-1:0]          y;
  logic signed [CW-1:0]          z;
  logic [stg_pkg::ATAN_IW-1:0]   step;
  logic                          busy;
  logic                          done;
  logic                          neg;

  logic signed [24:0]            a_ext;
  logic signed [24:0]            offset;
  logic signed [24:0]            z_fold;
  logic                          neg_fold;
  logic signed [CW-1:0]          xs;
  logic signed [CW-1:0]          ys;
  logic signed [CW-1:0]          at;

  // Fold an angle inside one turn into [-90, 90] degrees with one add; a half-turn
  // fold flips the sign of both results.
  always_comb begin
    a_ext    = {angle[23], angle};
    offset   = '0;
    neg_fold = 1'b0;
    if (a_ext > stg_pkg::DEG180_Q14) begin
      if (a_ext < stg_pkg::DEG270_Q14) begin
        offset   = -stg_pkg::DEG180_Q14;
        neg_fold = 1'b1;
      end else begin
        offset = -stg_pkg::DEG360_Q14;
      end
    end else if (a_ext < -stg_pkg::DEG180_Q14) begin
      if (a_ext > -stg_pkg::DEG270_Q14) begin
        offset   = stg_pkg::DEG180_Q14;
        neg_fold = 1'b1;
      end else begin
        offset = stg_pkg::DEG360_Q14;
      end
    end else if (a_ext > stg_pkg::DEG90_Q14) begin
      offset   = -stg_pkg::DEG180_Q14;
      neg_fold = 1'b1;
    end else if (a_ext < -stg_pkg::DEG90_Q14) begin
      offset   = stg_pkg::DEG180_Q14;
      neg_fold = 1'b1;
    end
    z_fold = a_ext + offset;
  end

  // Shifted vector terms and the current arctangent.
  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    at = CW'(stg_pkg::atan_deg(step));
  end

  // Rotation sequencer: load on start, then one micro-rotation per cycle.
  // The done pulse follows the cycle of the last rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Vector and residual angle registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= stg_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= {z_fold[23:0], 10'b0};
      neg  <= neg_fold;
      step <= '0;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      step <= step + 1'b1;
    end
  end

  // Results, with the sign restored after a half-turn fold.
  always_comb begin
    stat.done    = done;
    stat.sin_val = neg ? -y : y;
    stat.cos_val = neg ? -x : x;
  end

endmodule

`default_nettype wire

// ===== rtl/core/spiral_trajectory_generator_top.sv =====
// Spiral trajectory generator: per tick, advances the angle, places the point
// on the spiral around the configured centre, then damps speed and grows radius.
// Depends on stg_pkg, stg_mul and stg_cordic.
//
// Usage:
//  - Tick channel (tick_valid / tick_stall, delta_time, restart): one transfer
//    per time tick. tick_stall is high while a tick is being worked on.
//  - Result channel (result_valid / result_stall, pos_x, pos_y, angle_out):
//    exactly one result per tick, held in an output register until taken.
//  - Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
//    write only while no tick is in flight. Unknown indexes are ignored.
//  - Sequencing: a tick runs through the sequencer states in order, and the next
//    tick is taken only after the sequencer has returned to idle. The CORDIC
//    rotations, one per cycle, and the single shared multiplier, used ten times
//    per tick, set the length of a tick.
//  - A new tick is taken while the previous result still waits; if the
//    receiver stalls, the finished tick waits in its last state until the
//    output register frees up.
//  - Reset (synchronous, active high) clears the state to angle 0, speed 0,
//    radius 66, and the registers to their reset values.
`default_nettype none

module spiral_trajectory_generator_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Tick channel
  input  wire logic               tick_valid,
  output      logic               tick_stall,
  input  wire logic [15:0]        delta_time,
  input  wire logic               restart,
  // Result channel
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      logic signed [23:0] pos_x,
  output      logic signed [23:0] pos_y,
  output      logic signed [23:0] angle_out,
  // Configuration channel
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int AW = stg_pkg::MUL_A_W;
  localparam int BW = stg_pkg::MUL_B_W;
  localparam int PW = stg_pkg::MUL_P_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MSTEP  = 4'd1;
  localparam logic [3:0] S_WRAP   = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_CLOAD  = 4'd4;
  localparam logic [3:0] S_CRUN   = 4'd5;
  localparam logic [3:0] S_PX_HI  = 4'd6;
  localparam logic [3:0] S_PX_LO  = 4'd7;
  localparam logic [3:0] S_PX_SCL = 4'd8;
  localparam logic [3:0] S_PY_HI  = 4'd9;
  localparam logic [3:0] S_PY_LO  = 4'd10;
  localparam logic [3:0] S_PY_SCL = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  // Configuration registers.
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [19:0]        min_speed;
  logic [19:0]        max_speed;
  logic [19:0]        expansion_rate;
  logic               clockwise;
  logic [15:0]        inv_scale;

  // Tick state and working registers.
  logic [3:0]         state;
  logic [1:0]         cnt;
  logic [15:0]        dt;
  logic signed [23:0] angle;
  logic [19:0]        speed;
  logic [31:0]        radius;
  logic [26:0]        mag;
  logic               nsign;
  logic [19:0]        dec;
  logic [27:0]        grow;
  logic signed [PW-1:0] acc;
  logic signed [23:0] px;

  // Shared units.
  logic                 mul_go;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic                 cordic_start;
  stg_pkg::trig_t       cstat;

  // Combinational helpers.
  logic               tick_xfer;
  logic               res_free;
  logic [25:0]        step;
  logic signed [27:0] na;
  logic [26:0]        modv;
  logic [26:0]        mag_new;
  logic [23:0]        mag24;
  logic signed [stg_pkg::CW-1:0] trig;
  logic signed [65:0] hi_ext;
  logic signed [65:0] lo_ext;
  logic signed [65:0] tsum;
  logic signed [28:0] pctr;
  logic signed [28:0] ppos;
  logic signed [23:0] scaled;
  logic [32:0]        r_sum;

  assign cfg_ready  = 1'b1;
  assign tick_stall = (state != S_IDLE);
  assign tick_xfer  = tick_valid && !tick_stall;
  assign res_free   = !result_valid || !result_stall;
  assign cordic_start = (state == S_CLOAD);

  stg_mul u_mul (
    .clk (clk),
    .go  (mul_go),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  stg_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (angle),
    .stat  (cstat)
  );

  // Angle step, wrap and remainder sweep arithmetic.
  always_comb begin
    step    = prod[35:10];
    na      = clockwise ? ({{4{angle[23]}}, angle} + {2'b00, step})
                        : ({{4{angle[23]}}, angle} - {2'b00, step});
    modv    = stg_pkg::DEG360_MAG << cnt;
    mag_new = (mag >= modv) ? (mag - modv) : mag;
    mag24   = mag_new[23:0];
  end

  // Position arithmetic: radius times sin or cos from two half products,
  // floored by 2^38, plus the centre; scaled output and radius sum.
  always_comb begin
    if (state == S_PX_HI || state == S_PX_LO || state == S_PX_SCL) begin
      trig = cstat.sin_val;
      pctr = {{5{center_x[23]}}, center_x};
    end else begin
      trig = cstat.cos_val;
      pctr = {{5{center_y[23]}}, center_y};
    end
    hi_ext = {{(66 - PW){acc[PW-1]}}, acc};
    lo_ext = {{(66 - PW){prod[PW-1]}}, prod};
    tsum   = (hi_ext <<< 16) + lo_ext;
    ppos   = pctr + {tsum[65], tsum[65:38]};
    scaled = stg_pkg::sat24(prod[55:16]);
    r_sum  = {1'b0, radius} + {5'b0, grow};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_MSTEP: begin
        mul_go = 1'b1;
        mul_a  = AW'(speed);
        mul_b  = BW'(dt);
      end
      S_WRAP: begin
        mul_go = 1'b1;
        mul_a  = AW'(max_speed);
        mul_b  = BW'(dt);
      end
      S_MOD: begin
        if (cnt == 2'd3) begin
          mul_go = 1'b1;
          mul_a  = AW'(prod[35:16]);
          mul_b  = stg_pkg::RECIP20;
        end else if (cnt == 2'd2) begin
          mul_go = 1'b1;
          mul_a  = AW'(expansion_rate);
          mul_b  = BW'(dt);
        end
      end
      S_PX_HI, S_PY_HI: begin
        mul_go = 1'b1;
        mul_a  = {trig[stg_pkg::CW-1], trig};
        mul_b  = BW'(radius[31:16]);
      end
      S_PX_LO, S_PY_LO: begin
        mul_go = 1'b1;
        mul_a  = {trig[stg_pkg::CW-1], trig};
        mul_b  = BW'(radius[15:0]);
      end
      S_PX_SCL, S_PY_SCL: begin
        mul_go = 1'b1;
        mul_a  = {{(AW - 29){ppos[28]}}, ppos};
        mul_b  = BW'(inv_scale);
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      min_speed      <= '0;
      max_speed      <= '0;
      expansion_rate <= '0;
      clockwise      <= 1'b1;
      inv_scale      <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stg_pkg::REG_CENTER_X:  center_x       <= cfg_data;
        stg_pkg::REG_CENTER_Y:  center_y       <= cfg_data;
        stg_pkg::REG_MIN_SPEED: min_speed      <= cfg_data[19:0];
        stg_pkg::REG_MAX_SPEED: max_speed      <= cfg_data[19:0];
        stg_pkg::REG_EXP_RATE:  expansion_rate <= cfg_data[19:0];
        stg_pkg::REG_CLOCKWISE: clockwise      <= cfg_data[0];
        stg_pkg::REG_INV_SCALE: inv_scale      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Result valid flag: set when a finished tick is stored, cleared on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FIN && res_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Tick sequencer and persistent state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      angle        <= '0;
      speed        <= '0;
      radius       <= stg_pkg::RADIUS_START;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tick_xfer) begin
            if (restart) begin
              radius <= stg_pkg::RADIUS_START;
              speed  <= max_speed;
              angle  <= '0;
            end
            state <= S_MSTEP;
          end
        end
        S_MSTEP: state <= S_WRAP;
        S_WRAP: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (cnt == 2'd0) begin
            angle <= nsign ? $signed(-mag24) : $signed(mag24);
            state <= S_CLOAD;
          end
        end
        S_CLOAD: state <= S_CRUN;
        S_CRUN: begin
          if (cstat.done) begin
            state <= S_PX_HI;
          end
        end
        S_PX_HI:  state <= S_PX_LO;
        S_PX_LO:  state <= S_PX_SCL;
        S_PX_SCL: state <= S_PY_HI;
        S_PY_HI:  state <= S_PY_LO;
        S_PY_LO:  state <= S_PY_SCL;
        S_PY_SCL: state <= S_FIN;
        S_FIN: begin
          if (res_free) begin
            if (speed > min_speed) begin
              speed <= (dec >= speed) ? 20'd0 : (speed - dec);
            end
            radius <= r_sum[32] ? 32'hFFFF_FFFF : r_sum[31:0];
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      dt <= delta_time;
    end
    if (state == S_WRAP) begin
      mag   <= na[27] ? 27'(-na) : 27'(na);
      nsign <= na[27];
      cnt   <= 2'd3;
    end
    if (state == S_MOD) begin
      mag <= mag_new;
      cnt <= cnt - 2'd1;
      if (cnt == 2'd2) begin
        dec <= prod[43:24];
      end
      if (cnt == 2'd1) begin
        grow <= prod[35:8];
      end
    end
    if (state == S_PX_LO || state == S_PY_LO) begin
      acc <= prod;
    end
    if (state == S_PY_HI) begin
      px <= scaled;
    end
    if (state == S_FIN && res_free) begin
      pos_x     <= px;
      pos_y     <= scaled;
      angle_out <= angle;
    end
  end

  // A transfer on the tick channel always starts a busy period.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_xfer |=> tick_stall)
    else $error("tick channel not stalled after a transfer");

  // The stored angle stays strictly inside one turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    ($signed({angle[23], angle}) < stg_pkg::DEG360_Q14) &&
    ($signed({angle[23], angle}) > -stg_pkg::DEG360_Q14))
    else $error("angle outside one turn");

  // The CORDIC unit only finishes while the sequencer waits for it.
  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cstat.done |-> (state == S_CRUN))
    else $error("CORDIC finished outside its wait state");

  // A finished tick waits while the output register holds a stalled result.
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && result_valid && result_stall) |=> (state == S_FIN))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== tb/spiral_trajectory_generator_top_tb.sv =====
// Testbench for spiral_trajectory_generator_top: register writes, a directed tick table,
// then random ticks, each checked against a typed-in point or a cycle-free predictor.
// Depends on stg_pkg (register indexes) and the block's RTL.
`default_nettype none

module spiral_trajectory_generator_top_tb;

  localparam int CORDIC_STEPS   = 16;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_TICKS    = 100;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = CORDIC_STEPS + 20;
  localparam int MAX_REPORTS    = 40;

  // Fixed-point constants: Q10.14 and Q24 degrees, Q2.30 vectors.
  localparam longint TURN_Q14    = 64'sd5898240;
  localparam longint QUARTER_Q24 = 64'sd1509949440;
  localparam longint HALF_Q24    = 64'sd3019898880;
  localparam longint TURN_Q24    = 64'sd6039797760;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint unsigned DAMP_DIV = 64'd1310720;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] ang;
  } spiral_point_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    idx;
    logic [23:0]   data;
    logic [15:0]   dt;
    logic          rs;
    logic          typed;
    spiral_point_t pt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              tick_valid   = 1'b0;
  logic              tick_stall;
  logic [15:0]       delta_time   = 16'd0;
  logic              restart      = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] angle_out;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index    = 3'd0;
  logic [23:0]       cfg_data     = 24'd0;

  // Predictor copy of the registers, at their reset values.
  longint      ctr_x       = 0;
  longint      ctr_y       = 0;
  logic [19:0] speed_floor = 20'd0;
  logic [19:0] speed_top   = 20'd0;
  logic [19:0] grow_rate   = 20'd0;
  logic        turn_cw     = 1'b1;
  logic [15:0] out_scale   = 16'hFFFF;

  // Predictor copy of the spiral state.
  longint      trk_angle  = 0;
  logic [19:0] trk_speed  = 20'd0;
  logic [31:0] trk_radius = 32'd66;

  // atan(2^-i) in Q24 degrees.
  longint atan_q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  spiral_point_t pending_points [$];
  stim_row_t     stim_table [$];

  int burst_left     = 0;
  int ticks_sent     = 0;
  int restarts_sent  = 0;
  int writes_done    = 0;
  int settings_used  = 0;
  int points_checked = 0;
  int rail_hits      = 0;
  int neg_angles     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  spiral_trajectory_generator_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .delta_time   (delta_time),
    .restart      (restart),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .angle_out    (angle_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Position along one axis: centre plus offset, scaled and clamped to Q16.8.
  function automatic longint place_axis(input longint centre, input longint trig);
    longint p;
    p = centre + ((longint'({32'd0, trk_radius}) * trig) >>> 38);
    p = (p * longint'({48'd0, out_scale})) >>> 16;
    if (p > 8388607) begin
      p = 8388607;
    end else if (p < -8388608) begin
      p = -8388608;
    end
    return p;
  endfunction

  // One tick of the spiral: move the angle, place the point, damp, grow.
  function automatic spiral_point_t advance_spiral(input logic [15:0] dt, input logic rs);
    longint step, z, x, y, nx, sn, cs, px, py;
    longint unsigned dec, grown;
    logic flip;
    int i;
    spiral_point_t pt;
    if (rs) begin
      trk_radius = 32'd66;
      trk_speed  = speed_top;
      trk_angle  = 0;
    end
    step = ({44'd0, trk_speed} * {48'd0, dt}) >> 10;
    trk_angle = (turn_cw ? trk_angle + step : trk_angle - step) % TURN_Q14;

    // Fold the angle into +-90 degrees, remembering a half-turn flip.
    z = trk_angle * 1024;
    flip = 1'b0;
    if (z > TURN_Q24 / 2) begin
      z -= TURN_Q24;
    end else if (z < -(TURN_Q24 / 2)) begin
      z += TURN_Q24;
    end
    if (z > QUARTER_Q24) begin
      z -= HALF_Q24;
      flip = 1'b1;
    end else if (z < -QUARTER_Q24) begin
      z += HALF_Q24;
      flip = 1'b1;
    end

    // CORDIC rotation in degrees; shifts floor toward minus infinity.
    x = GAIN_Q30;
    y = 0;
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_q24[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_q24[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;

    px = place_axis(ctr_x, sn);
    py = place_axis(ctr_y, cs);
    pt.x   = px[23:0];
    pt.y   = py[23:0];
    pt.ang = trk_angle[23:0];

    // Damping by 5% of the top speed per second, floored at zero.
    if (trk_speed > speed_floor) begin
      dec = ({44'd0, speed_top} * {48'd0, dt}) / DAMP_DIV;
      trk_speed = (dec >= {44'd0, trk_speed}) ? 20'd0 : trk_speed - dec[19:0];
    end

    // Radius growth, saturating at the top of 32 bits.
    grown = {32'd0, trk_radius} + (({44'd0, grow_rate} * {48'd0, dt}) >> 8);
    trk_radius = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    return pt;
  endfunction

  // Mirror of a register write; unknown indexes change nothing.
  function automatic void apply_reg(input logic [2:0] idx, input logic [23:0] data);
    case (idx)
      stg_pkg::REG_CENTER_X:  ctr_x = $signed(data);
      stg_pkg::REG_CENTER_Y:  ctr_y = $signed(data);
      stg_pkg::REG_MIN_SPEED: speed_floor = data[19:0];
      stg_pkg::REG_MAX_SPEED: speed_top = data[19:0];
      stg_pkg::REG_EXP_RATE:  grow_rate = data[19:0];
      stg_pkg::REG_CLOCKWISE: turn_cw = data[0];
      stg_pkg::REG_INV_SCALE: out_scale = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [23:0] rand24();
    int unsigned r;
    r = $urandom;
    return r[23:0];
  endfunction

  function automatic void add_tick(input logic [15:0] dt, input logic rs);
    stim_row_t r;
    r.kind  = ROW_TICK;
    r.idx   = 3'd0;
    r.data  = 24'd0;
    r.dt    = dt;
    r.rs    = rs;
    r.typed = 1'b0;
    r.pt    = '0;
    stim_table.push_back(r);
  endfunction

  function automatic void add_typed(input logic [15:0] dt, input logic rs,
                                    input logic [23:0] x, input logic [23:0] y,
                                    input logic [23:0] a);
    stim_row_t r;
    r.kind  = ROW_TICK;
    r.idx   = 3'd0;
    r.data  = 24'd0;
    r.dt    = dt;
    r.rs    = rs;
    r.typed = 1'b1;
    r.pt    = {x, y, a};
    stim_table.push_back(r);
  endfunction

  function automatic void add_write(input logic [2:0] idx, input logic [23:0] data);
    stim_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.dt    = 16'd0;
    r.rs    = 1'b0;
    r.typed = 1'b0;
    r.pt    = '0;
    stim_table.push_back(r);
  endfunction

  // Register write, issued only once every pending point has come back.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    if (tick_valid) begin
      tick_valid <= 1'b0;
    end
    while (pending_points.size() != 0) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
    writes_done++;
  endtask

  // Offer one tick, in bursts with random gaps, and queue its predicted or typed point.
  task automatic send_tick(input logic [15:0] dt, input logic rs, input logic typed,
                           input spiral_point_t typed_pt);
    int gap;
    spiral_point_t predicted;
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tick_valid <= 1'b1;
    delta_time <= dt;
    restart    <= rs;
    do @(posedge clk); while (tick_stall !== 1'b0);
    predicted = advance_spiral(dt, rs);
    pending_points.push_back(typed ? typed_pt : predicted);
    burst_left--;
    ticks_sent++;
    if (rs) begin
      restarts_sent++;
    end
  endtask

  task automatic note_mismatch(input string field, input logic [23:0] want,
                               input logic [23:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Result checker: every transfer on the result channel against the oldest point.
  always @(posedge clk) begin : result_check
    spiral_point_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (pending_points.size() == 0) begin
        note_mismatch("unexpected result, pos_x", 24'd0, pos_x);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (pos_x !== want.x) begin
          note_mismatch("pos_x", want.x, pos_x);
        end
        if (pos_y !== want.y) begin
          note_mismatch("pos_y", want.y, pos_y);
        end
        if (angle_out !== want.ang) begin
          note_mismatch("angle_out", want.ang, angle_out);
        end
        if (pos_x == 24'h7FFFFF || pos_x == 24'h800000 ||
            pos_y == 24'h7FFFFF || pos_y == 24'h800000) begin
          rail_hits++;
        end
        if (angle_out[23]) begin
          neg_angles++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (tick_valid && tick_stall === 1'b0) ||
        (result_valid === 1'b1 && !result_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall patterns in stretches, plus two long hold-offs that back up the block.
  initial begin : receiver
    int mode;
    int span;
    int holds_done;
    holds_done = 0;
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        if (holds_done < 2 && points_checked >= ((holds_done == 0) ? 150 : 600)) begin
          result_stall <= 1'b1;
          holds_done++;
          repeat (LONG_HOLD) @(posedge clk);
        end else begin
          case (mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ~result_stall;
          endcase
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    stim_row_t row;
    logic [15:0] dt;
    logic rs;
    logic [23:0] v_cx, v_cy, v_min, v_max, v_exp, v_cw, v_inv;
    int k;
    int ph;
    int n;
    int pick;
    int unsigned rnd;

    // Directed table. With a zero scale the positions are zero, so the angle
    // of those rows can be read straight off the speed and time step.
    add_tick(16'h0000, 1'b0);
    add_tick(16'hFFFF, 1'b0);
    add_write(stg_pkg::REG_INV_SCALE, 24'h000000);
    add_write(stg_pkg::REG_MAX_SPEED, 24'h000100);
    add_typed(16'h0000, 1'b1, 24'h000000, 24'h000000, 24'h000000);
    add_typed(16'h8000, 1'b0, 24'h000000, 24'h000000, 24'h002000);
    add_write(stg_pkg::REG_CLOCKWISE, 24'h000000);
    add_typed(16'h8000, 1'b1, 24'h000000, 24'h000000, 24'hFFE000);
    // Full speed: the angle wraps on every tick and the speed damps down.
    add_write(stg_pkg::REG_CLOCKWISE, 24'h000001);
    add_write(stg_pkg::REG_MAX_SPEED, 24'h0FFFFF);
    add_tick(16'hFFFF, 1'b1);
    repeat (3) add_tick(16'hFFFF, 1'b0);
    // Centre on the rails and fastest growth: positions saturate, radius climbs.
    add_write(stg_pkg::REG_INV_SCALE, 24'h00FFFF);
    add_write(stg_pkg::REG_CENTER_X, 24'h7FFFFF);
    add_write(stg_pkg::REG_CENTER_Y, 24'h800000);
    add_write(stg_pkg::REG_EXP_RATE, 24'h0FFFFF);
    repeat (6) add_tick(16'hFFFF, 1'b0);
    add_tick(16'h0001, 1'b1);
    // Speed floor at the top disables damping; a write past the last index is dropped.
    add_write(stg_pkg::REG_MIN_SPEED, 24'h0FFFFF);
    add_write(REG_UNUSED, 24'hFFFFFF);
    add_tick(16'hFFFF, 1'b1);
    add_tick(16'hFFFF, 1'b0);
    add_write(stg_pkg::REG_INV_SCALE, 24'h000001);
    add_tick(16'hAAAA, 1'b0);
    add_tick(16'h5555, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    settings_used = 1;
    for (k = 0; k < stim_table.size(); k++) begin
      row = stim_table[k];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.idx, row.data);
      end else begin
        send_tick(row.dt, row.rs, row.typed, row.pt);
      end
    end

    // Random phases: extreme settings first, then random ones with junk upper bits.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          v_cx = 24'h7FFFFF; v_cy = 24'h7FFFFF; v_min = 24'h0; v_max = 24'hFFFFF;
          v_exp = 24'hFFFFF; v_cw = 24'h1; v_inv = 24'hFFFF;
        end
        1: begin
          v_cx = 24'h800000; v_cy = 24'h800000; v_min = 24'h0; v_max = 24'h0;
          v_exp = 24'h0; v_cw = 24'h0; v_inv = 24'h1;
        end
        2: begin
          v_cx = 24'h800000; v_cy = 24'h7FFFFF; v_min = 24'h0; v_max = 24'hFFFFF;
          v_exp = 24'hFFFFF; v_cw = 24'h0; v_inv = 24'hFFFF;
        end
        3: begin
          v_cx = 24'h0; v_cy = 24'h0; v_min = 24'hFFFFF; v_max = 24'hFFFFF;
          v_exp = 24'h3FF; v_cw = 24'h1; v_inv = 24'h0;
        end
        default: begin
          v_cx = rand24();
          v_cy = rand24();
          v_min = rand24();
          if ($urandom_range(0, 3) == 0) begin
            v_min[19:0] = 20'd0;
          end
          v_max = rand24();
          v_exp = rand24();
          if ($urandom_range(0, 1) == 1) begin
            v_exp[19:10] = 10'd0;
          end
          v_cw = rand24();
          v_inv = rand24();
          if ($urandom_range(0, 7) == 0) begin
            v_inv[15:0] = 16'd0;
          end
        end
      endcase
      write_reg(stg_pkg::REG_CENTER_X, v_cx);
      write_reg(stg_pkg::REG_CENTER_Y, v_cy);
      write_reg(stg_pkg::REG_MIN_SPEED, v_min);
      write_reg(stg_pkg::REG_MAX_SPEED, v_max);
      write_reg(stg_pkg::REG_EXP_RATE, v_exp);
      write_reg(stg_pkg::REG_CLOCKWISE, v_cw);
      write_reg(stg_pkg::REG_INV_SCALE, v_inv);
      if (ph % 2 == 1) begin
        write_reg(REG_UNUSED, rand24());
      end
      settings_used++;

      // Each phase opens with a restart, then runs ticks with the odd restart.
      for (n = 0; n < PHASE_TICKS; n++) begin
        rs = (n == 0) || ($urandom_range(0, 31) == 0);
        pick = $urandom_range(0, 9);
        rnd = $urandom;
        if (pick == 0) begin
          dt = 16'h0000;
        end else if (pick == 1) begin
          dt = 16'hFFFF;
        end else if (pick <= 3) begin
          dt = {8'd0, rnd[7:0]};
        end else begin
          dt = rnd[15:0];
        end
        send_tick(dt, rs, 1'b0, '0);
      end
    end

    // Drain: wait for every point, then let the clock run on for strays.
    if (tick_valid) begin
      tick_valid <= 1'b0;
    end
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    while (pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks (%0d with restart) under %0d register settings, %0d writes.",
             ticks_sent, restarts_sent, settings_used, writes_done);
    $display("Checked %0d points: %0d on a rail, %0d with negative angle, %0d mismatches.",
             points_checked, rail_hits, neg_angles, mismatch_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
